@@ rtl/core/tbpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_pkg
// Shared sizes, codes and types of the tiled background pixel fetch.
// ----------------------------------------------------------------------------
package tbpf_pkg;

  // Storage sizes in bytes
  localparam int VIDEO_BYTES   = 65536;
  localparam int PALETTE_BYTES = 512;

  // Derived address widths; both memories are split into even/odd byte lanes
  localparam int VA_W = $clog2(VIDEO_BYTES);
  localparam int VW_W = VA_W - 1;
  localparam int PA_W = $clog2(PALETTE_BYTES);
  localparam int PW_W = PA_W - 1;

  // Width of intermediate address sums before the wrap to the memory size
  localparam int CALC_W = 18;

  // Layout constants
  localparam int CHAR_BLOCK_BYTES = 'h4000;
  localparam int MAP_BLOCK_BYTES  = 'h800;
  localparam int MAP_ROW_BYTES    = 64;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // Input actions
  typedef logic [1:0] action_t;
  localparam action_t ACT_VRAM_WR  = 2'd0;
  localparam action_t ACT_PAL_WR   = 2'd1;
  localparam action_t ACT_FETCH    = 2'd2;
  localparam action_t ACT_RESERVED = 2'd3;

  // Configuration register indexes
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_CHAR_BASE = 3'd0;
  localparam cfg_index_t REG_MAP_BASE  = 3'd1;
  localparam cfg_index_t REG_COLOR_8BPP = 3'd2;
  localparam cfg_index_t REG_MAP_WIDE  = 3'd3;
  localparam cfg_index_t REG_MAP_TALL  = 3'd4;
  localparam cfg_index_t REG_SCROLL_X  = 3'd5;
  localparam cfg_index_t REG_SCROLL_Y  = 3'd6;
  localparam int CFG_DATA_W = 9;

  // Classified command handed from front to back
  typedef struct packed {
    action_t          kind;
    logic [15:0]      addr;
    logic [7:0]       data;
    logic [VW_W-1:0]  map_word;
    logic [2:0]       col;
    logic [2:0]       row;
  } cmd_t;

  // Configuration the back end needs
  typedef struct packed {
    logic [1:0] char_base;
    logic       color_8bpp;
  } back_cfg_t;

endpackage

@@ rtl/core/tbpf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_in_if / tbpf_out_if
// Valid/ready channels for input items and result pixels.
// ----------------------------------------------------------------------------
interface tbpf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [15:0] mem_address;
  logic [7:0]  write_data;

  modport source (output valid, action, pixel_x, pixel_y, mem_address, write_data,
                  input ready);
  modport sink   (input valid, action, pixel_x, pixel_y, mem_address, write_data,
                  output ready);
endinterface

interface tbpf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_rgba;

  modport source (output valid, pixel_rgba, input ready);
  modport sink   (input valid, pixel_rgba, output ready);
endinterface

@@ rtl/core/tiled_background_pixel_fetch.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_background_pixel_fetch
// Text-mode tiled background renderer: video/palette byte writes and
// per-pixel color fetch with scroll, map wrap, flips and 4/8bpp tiles.
// ----------------------------------------------------------------------------
// In the back end a pixel fetch reads the 16-bit map entry, the tile data
// word and the palette color word in turn and then loads the output
// register, waiting while a finished pixel stalls on out_bus; these three
// dependent memory reads on the single read port of each memory set the
// rate. A video or palette byte write is done as the item leaves the queue
// and gives no result. The reserved action is accepted and dropped in the
// front end and never reaches the back end. The front end takes an item
// whenever the two-entry command queue has room, so items keep coming in
// while a fetch runs or a finished pixel waits on out_bus. Results come
// out in input order. Video memory is 64 KB and palette memory 512 bytes,
// both undefined until written; addresses wrap to their size. Write the
// configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module tiled_background_pixel_fetch
  import tbpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tbpf_in_if.sink               in_bus,
  tbpf_out_if.source            out_bus
);

  logic      q_full, q_empty, q_push, q_pop;
  cmd_t      q_cmd, q_head;
  back_cfg_t back_cfg;

  // Accept, classify, compute the map entry address
  tbpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_bus   (in_bus),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .back_cfg (back_cfg)
  );

  // Decouple the two sides so each can stall on its own
  tbpf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // Carry out writes and fetches in order
  tbpf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .back_cfg(back_cfg),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

endmodule

@@ rtl/core/tbpf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_queue
// Small FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module tbpf_queue
  import tbpf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t            slot_r [Q_DEPTH];
  logic [QP_W-1:0] wptr_r;
  logic [QP_W-1:0] rptr_r;
  logic [QC_W-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == QC_W'(Q_DEPTH));
  assign head  = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/core/tbpf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_front
// Configuration registers, input acceptance and classification; computes
// the scrolled map entry address of a fetch.
// ----------------------------------------------------------------------------
module tbpf_front
  import tbpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tbpf_in_if.sink               in_bus,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  output back_cfg_t             back_cfg
);

  logic [1:0] char_base_r;
  logic [4:0] map_base_r;
  logic       color_8bpp_r;
  logic       map_wide_r;
  logic       map_tall_r;
  logic [8:0] scroll_x_r;
  logic [8:0] scroll_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_base_r  <= '0;
      map_base_r   <= '0;
      color_8bpp_r <= 1'b0;
      map_wide_r   <= 1'b0;
      map_tall_r   <= 1'b0;
      scroll_x_r   <= '0;
      scroll_y_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHAR_BASE:  char_base_r  <= cfg_data[1:0];
        REG_MAP_BASE:   map_base_r   <= cfg_data[4:0];
        REG_COLOR_8BPP: color_8bpp_r <= cfg_data[0];
        REG_MAP_WIDE:   map_wide_r   <= cfg_data[0];
        REG_MAP_TALL:   map_tall_r   <= cfg_data[0];
        REG_SCROLL_X:   scroll_x_r   <= cfg_data;
        REG_SCROLL_Y:   scroll_y_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign back_cfg = '{char_base: char_base_r, color_8bpp: color_8bpp_r};

  // Scrolled position, wrapped to a 256 or 512 pixel map
  logic [8:0]        sum_x, sum_y, map_x, map_y;
  logic [1:0]        blk;
  logic [CALC_W-1:0] map_addr;

  always_comb begin
    sum_x = {1'b0, in_bus.pixel_x} + scroll_x_r;
    sum_y = {1'b0, in_bus.pixel_y} + scroll_y_r;
    map_x = {sum_x[8] & map_wide_r, sum_x[7:0]};
    map_y = {sum_y[8] & map_tall_r, sum_y[7:0]};
    // Screen block: right half adds one, bottom half adds the blocks per row
    blk = {1'b0, map_x[8]} + (map_wide_r ? {map_y[8], 1'b0} : {1'b0, map_y[8]});
    map_addr = (CALC_W'(map_base_r) + CALC_W'(blk)) * CALC_W'(MAP_BLOCK_BYTES)
             + CALC_W'(map_y[7:3]) * CALC_W'(MAP_ROW_BYTES)
             + CALC_W'({map_x[7:3], 1'b0});
  end

  assign in_bus.ready = !q_full;

  always_comb begin
    q_cmd.kind     = in_bus.action;
    q_cmd.addr     = in_bus.mem_address;
    q_cmd.data     = in_bus.write_data;
    q_cmd.map_word = map_addr[VA_W-1:1];
    q_cmd.col      = map_x[2:0];
    q_cmd.row      = map_y[2:0];
  end

  // Drop the reserved action: accepted, never queued
  always_comb begin
    q_push = 1'b0;
    if (in_bus.valid && !q_full) begin
      unique case (in_bus.action) inside
        ACT_VRAM_WR, ACT_PAL_WR, ACT_FETCH: q_push = 1'b1;
        default:                            q_push = 1'b0;
      endcase
    end
  end

endmodule

@@ rtl/core/tbpf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_back
// Memory writes and the fetch sequencer: map entry, tile data and palette
// reads, then the output register.
// ----------------------------------------------------------------------------
module tbpf_back
  import tbpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  back_cfg_t back_cfg,
  input  cmd_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  tbpf_out_if.source out_bus
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAP  = 2'd1;
  localparam logic [1:0] ST_TILE = 2'd2;
  localparam logic [1:0] ST_PAL  = 2'd3;

  localparam int VW_DEPTH = VIDEO_BYTES / 2;
  localparam int PW_DEPTH = PALETTE_BYTES / 2;

  // Byte-lane memories: even and odd bytes of each 16-bit word
  logic [7:0] vram_lo_mem [VW_DEPTH];
  logic [7:0] vram_hi_mem [VW_DEPTH];
  logic [7:0] pal_lo_mem  [PW_DEPTH];
  logic [7:0] pal_hi_mem  [PW_DEPTH];

  logic [1:0]  st_r, st_nxt;
  logic [2:0]  col_r, row_r;
  logic [3:0]  bank_r;
  logic        nib_hi_r;
  logic        byte_hi_r;
  logic [7:0]  vrd_lo_r, vrd_hi_r;
  logic [7:0]  prd_lo_r, prd_hi_r;
  logic        out_valid_r;
  logic [31:0] out_rgba_r;

  logic            idle_take;
  logic            vram_wr, pal_wr;
  logic [CALC_W-1:0] wr_addr;
  logic            vrd_en;
  logic [VW_W-1:0] vrd_addr;
  logic            prd_en;
  logic [7:0]      pal_idx;
  logic            out_load;

  // Map entry fields and tile address
  logic [15:0]       entry;
  logic [2:0]        col_f, row_f;
  logic [CALC_W-1:0] tile_addr;
  logic [7:0]        tile_byte;
  logic [14:0]       color;

  assign idle_take = (st_r == ST_IDLE) && !q_empty;
  assign q_pop     = idle_take;
  assign vram_wr   = idle_take && (head.kind == ACT_VRAM_WR);
  assign pal_wr    = idle_take && (head.kind == ACT_PAL_WR);
  assign wr_addr   = CALC_W'(head.addr);

  always_comb begin
    entry = {vrd_hi_r, vrd_lo_r};
    col_f = entry[10] ? ~col_r : col_r;
    row_f = entry[11] ? ~row_r : row_r;
    if (back_cfg.color_8bpp) begin
      tile_addr = CALC_W'(back_cfg.char_base) * CALC_W'(CHAR_BLOCK_BYTES)
                + CALC_W'({entry[9:0], 6'd0}) + CALC_W'({row_f, col_f});
    end else begin
      tile_addr = CALC_W'(back_cfg.char_base) * CALC_W'(CHAR_BLOCK_BYTES)
                + CALC_W'({entry[9:0], 5'd0}) + CALC_W'({row_f, col_f[2:1]});
    end
  end

  always_comb begin
    tile_byte = byte_hi_r ? vrd_hi_r : vrd_lo_r;
    if (back_cfg.color_8bpp) begin
      pal_idx = tile_byte;
    end else begin
      pal_idx = {bank_r, nib_hi_r ? tile_byte[7:4] : tile_byte[3:0]};
    end
  end

  always_comb begin
    vrd_en   = 1'b0;
    vrd_addr = head.map_word;
    if (idle_take && (head.kind == ACT_FETCH)) begin
      vrd_en = 1'b1;
    end else if (st_r == ST_MAP) begin
      vrd_en   = 1'b1;
      vrd_addr = tile_addr[VA_W-1:1];
    end
  end

  assign prd_en   = (st_r == ST_TILE);
  assign out_load = (st_r == ST_PAL) && (!out_valid_r || out_bus.ready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (idle_take && (head.kind == ACT_FETCH)) st_nxt = ST_MAP;
      ST_MAP:  st_nxt = ST_TILE;
      ST_TILE: st_nxt = ST_PAL;
      ST_PAL:  if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Memory write and read ports
  always_ff @(posedge clk) begin
    if (vram_wr) begin
      if (wr_addr[0]) begin
        vram_hi_mem[wr_addr[VA_W-1:1]] <= head.data;
      end else begin
        vram_lo_mem[wr_addr[VA_W-1:1]] <= head.data;
      end
    end
    if (vrd_en) begin
      vrd_lo_r <= vram_lo_mem[vrd_addr];
      vrd_hi_r <= vram_hi_mem[vrd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      if (head.addr[0]) begin
        pal_hi_mem[head.addr[PA_W-1:1]] <= head.data;
      end else begin
        pal_lo_mem[head.addr[PA_W-1:1]] <= head.data;
      end
    end
    if (prd_en) begin
      prd_lo_r <= pal_lo_mem[PW_W'(pal_idx)];
      prd_hi_r <= pal_hi_mem[PW_W'(pal_idx)];
    end
  end

  // Per-fetch payload
  always_ff @(posedge clk) begin
    if (idle_take) begin
      col_r <= head.col;
      row_r <= head.row;
    end
    if (st_r == ST_MAP) begin
      bank_r    <= entry[15:12];
      nib_hi_r  <= col_f[0];
      byte_hi_r <= tile_addr[0];
    end
  end

  assign color = {prd_hi_r[6:0], prd_lo_r};

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rgba_r <= {color[4:0], 3'd0, color[9:5], 3'd0, color[14:10], 3'd0, 8'hFF};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.pixel_rgba = out_rgba_r;

endmodule

@@ rtl/core/tbpf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_checker
// Port-level checks of the tiled background pixel fetch.
// ----------------------------------------------------------------------------
module tbpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_rgba
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rgba))
    else $error("result beat changed while stalled");

  // Reset empties the block
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // Alpha is opaque and channels are multiples of eight
  a_rgba_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rgba[7:0] == 8'hFF) && (out_rgba[26:24] == 3'd0)
                  && (out_rgba[18:16] == 3'd0) && (out_rgba[10:8] == 3'd0))
    else $error("malformed pixel color");

  // A fresh result never appears right after reset
  a_no_early_out: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> !out_valid)
    else $error("result right after reset");

endmodule

bind tiled_background_pixel_fetch tbpf_checker u_tbpf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_bus.ready),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_rgba (out_bus.pixel_rgba)
);

@@ tb/sv/tbpf_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpf_pixel_checker
// Watches the item, pixel and register ports of the tiled background pixel
// fetch, keeps shadow copies of both memories and the settings, predicts
// the color of every fetched pixel and compares it with what comes out.
// ----------------------------------------------------------------------------
module tbpf_pixel_checker
  import tbpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tbpf_in_if                    in_mon,
  tbpf_out_if                   out_mon,
  output int                    mismatch_count,
  output int                    pixels_pending
);

  // Shadow storage and settings
  logic [7:0] vram_copy [VIDEO_BYTES];
  logic [7:0] pram_copy [PALETTE_BYTES];
  logic [1:0] tile_base;
  logic [4:0] map_base;
  logic       deep_color;
  logic       wide_map;
  logic       tall_map;
  logic [8:0] hscroll;
  logic [8:0] vscroll;

  logic [31:0] pending_rgba [$];
  logic [31:0] oldest_rgba;

  initial begin
    mismatch_count = 0;
    pixels_pending = 0;
  end

  task automatic report_mismatch(string what);
    $display("[%0t] pixel check: %s", $time, what);
    mismatch_count++;
  endtask

  // Color of screen pixel (px, py) under the current shadow state
  function automatic logic [31:0] render_pixel(logic [7:0] px, logic [7:0] py);
    int          wmask, hmask, x, y, tx, ty, blk, maddr, caddr, col, row, tile, idx;
    logic [15:0] entry;
    logic [15:0] color;
    wmask = wide_map ? 511 : 255;
    hmask = tall_map ? 511 : 255;
    x     = (int'(px) + int'(hscroll)) & wmask;
    y     = (int'(py) + int'(vscroll)) & hmask;
    tx    = x >> 3;
    ty    = y >> 3;
    blk   = (tx >> 5) + (ty >> 5) * (wide_map ? 2 : 1);
    maddr = int'(map_base) * MAP_BLOCK_BYTES + blk * MAP_BLOCK_BYTES
          + (ty & 31) * MAP_ROW_BYTES + (tx & 31) * 2;
    entry = {vram_copy[(maddr + 1) % VIDEO_BYTES], vram_copy[maddr % VIDEO_BYTES]};
    col   = x & 7;
    row   = y & 7;
    tile  = int'(entry[9:0]);
    if (entry[10]) col = 7 - col;
    if (entry[11]) row = 7 - row;
    if (deep_color) begin
      caddr = int'(tile_base) * CHAR_BLOCK_BYTES + tile * 64 + row * 8 + col;
      idx   = int'(vram_copy[caddr % VIDEO_BYTES]);
    end else begin
      // 4bpp: the flipped column picks the byte and then the nibble
      caddr = int'(tile_base) * CHAR_BLOCK_BYTES + tile * 32 + row * 4 + (col >> 1);
      idx   = (int'(vram_copy[caddr % VIDEO_BYTES]) >> ((col & 1) * 4)) & 'hF;
      idx   = idx + int'(entry[15:12]) * 16;
    end
    color = {pram_copy[(idx * 2 + 1) % PALETTE_BYTES], pram_copy[(idx * 2) % PALETTE_BYTES]};
    // bit 15 of the color drops out here
    return {color[4:0], 3'b000, color[9:5], 3'b000, color[14:10], 3'b000, 8'hFF};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tile_base  = '0;
      map_base   = '0;
      deep_color = 1'b0;
      wide_map   = 1'b0;
      tall_map   = 1'b0;
      hscroll    = '0;
      vscroll    = '0;
      pending_rgba.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CHAR_BASE:  tile_base  = cfg_data[1:0];
          REG_MAP_BASE:   map_base   = cfg_data[4:0];
          REG_COLOR_8BPP: deep_color = cfg_data[0];
          REG_MAP_WIDE:   wide_map   = cfg_data[0];
          REG_MAP_TALL:   tall_map   = cfg_data[0];
          REG_SCROLL_X:   hscroll    = cfg_data[8:0];
          REG_SCROLL_Y:   vscroll    = cfg_data[8:0];
          default: ;
        endcase
      end
      // Compare outgoing beats before queueing new fetches
      if (out_mon.valid && out_mon.ready) begin
        if (pending_rgba.size() == 0) begin
          report_mismatch($sformatf("pixel %08h arrived with none expected",
                                    out_mon.pixel_rgba));
        end else begin
          oldest_rgba = pending_rgba.pop_front();
          if (out_mon.pixel_rgba !== oldest_rgba)
            report_mismatch($sformatf("pixel_rgba %08h, expected %08h",
                                      out_mon.pixel_rgba, oldest_rgba));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.action)
          ACT_VRAM_WR: vram_copy[int'(in_mon.mem_address) % VIDEO_BYTES] = in_mon.write_data;
          ACT_PAL_WR:  pram_copy[int'(in_mon.mem_address) % PALETTE_BYTES] = in_mon.write_data;
          ACT_FETCH:   pending_rgba.push_back(render_pixel(in_mon.pixel_x, in_mon.pixel_y));
          default: ;
        endcase
      end
    end
    pixels_pending = pending_rgba.size();
  end

endmodule

@@ tb/sv/tiled_background_pixel_fetch_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_background_pixel_fetch_test
// Drives byte writes and pixel fetches into the tiled background pixel
// fetch under changing register settings and random stalls on both sides;
// a checker beside the block predicts every pixel and counts mismatches.
// ----------------------------------------------------------------------------
module tiled_background_pixel_fetch_test;
  import tbpf_pkg::*;

  // Cycles to let the block finish writes that give no pixel
  localparam int SETTLE_CYCLES = 12;
  // Upper bound on cycles spent draining at the end
  localparam int DRAIN_LIMIT   = 20000;
  // Random beats per register setting, preparing writes included
  localparam int BEATS_PER_SET = 67;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tbpf_in_if  in_bus ();
  tbpf_out_if out_bus ();

  int mismatch_count;
  int pixels_pending;

  // Stall percentages of the sender and the receiver
  int send_idle_pct;
  int recv_idle_pct;

  // Run statistics and the settings currently programmed
  int         n_fetch, n_vwrite, n_pwrite, n_reserved, n_settings, n_beats;
  logic [4:0] map_base_now;
  logic [1:0] char_base_now;
  logic       c8_now, wide_now, tall_now;
  logic [8:0] sx_now, sy_now;

  // Bytes written so far; a fetch only ever reads written bytes
  logic [7:0] vram_known [int];
  logic [7:0] pram_known [int];

  tiled_background_pixel_fetch uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  tbpf_pixel_checker pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .mismatch_count (mismatch_count),
    .pixels_pending (pixels_pending)
  );

  always #4 clk = ~clk;

  // Receiver: decide at each falling edge whether to take the next pixel
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop in case the block hangs
  initial begin
    #2ms;
    $display("timeout with %0d pixels outstanding", pixels_pending);
    $display("FAILED: results differ");
    $finish;
  end

  // Send one beat: idle at random first, then hold valid until it is taken.
  // Enter and leave at a falling edge.
  task automatic drive_beat(action_t act, logic [7:0] px, logic [7:0] py,
                            logic [15:0] addr, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.action      <= act;
    in_bus.pixel_x     <= px;
    in_bus.pixel_y     <= py;
    in_bus.mem_address <= addr;
    in_bus.write_data  <= data;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    case (act)
      ACT_VRAM_WR: begin
        vram_known[int'(addr)] = data;
        n_vwrite++;
      end
      ACT_PAL_WR: begin
        pram_known[int'(addr) % PALETTE_BYTES] = data;
        n_pwrite++;
      end
      ACT_FETCH:   n_fetch++;
      default:     n_reserved++;
    endcase
    n_beats++;
  endtask

  // Write a random byte to a video or palette address not yet written
  task automatic ensure_vram(int a);
    int wa;
    wa = a % VIDEO_BYTES;
    if (!vram_known.exists(wa))
      drive_beat(ACT_VRAM_WR, 8'($urandom), 8'($urandom), 16'(wa), 8'($urandom));
  endtask

  task automatic ensure_pram(int a);
    int wa;
    wa = a % PALETTE_BYTES;
    if (!pram_known.exists(wa))
      drive_beat(ACT_PAL_WR, 8'($urandom), 8'($urandom), 16'(wa), 8'($urandom));
  endtask

  // Fetch a pixel, first writing any byte that the fetch would read unwritten
  task automatic fetch_at(logic [7:0] px, logic [7:0] py);
    int          x, y, tx, ty, blk, maddr, caddr, col, row, idx;
    logic [15:0] entry;
    logic [7:0]  tbyte;
    x     = (int'(px) + int'(sx_now)) & (wide_now ? 511 : 255);
    y     = (int'(py) + int'(sy_now)) & (tall_now ? 511 : 255);
    tx    = x >> 3;
    ty    = y >> 3;
    blk   = (tx >> 5) + (ty >> 5) * (wide_now ? 2 : 1);
    maddr = (int'(map_base_now) + blk) * MAP_BLOCK_BYTES
          + (ty & 31) * MAP_ROW_BYTES + (tx & 31) * 2;
    ensure_vram(maddr);
    ensure_vram(maddr + 1);
    entry = {vram_known[(maddr + 1) % VIDEO_BYTES], vram_known[maddr % VIDEO_BYTES]};
    col   = entry[10] ? 7 - (x & 7) : (x & 7);
    row   = entry[11] ? 7 - (y & 7) : (y & 7);
    if (c8_now)
      caddr = int'(char_base_now) * CHAR_BLOCK_BYTES + int'(entry[9:0]) * 64
            + row * 8 + col;
    else
      caddr = int'(char_base_now) * CHAR_BLOCK_BYTES + int'(entry[9:0]) * 32
            + row * 4 + (col >> 1);
    ensure_vram(caddr);
    tbyte = vram_known[caddr % VIDEO_BYTES];
    if (c8_now)
      idx = int'(tbyte);
    else
      idx = int'(entry[15:12]) * 16 + ((int'(tbyte) >> ((col & 1) * 4)) & 'hF);
    ensure_pram(idx * 2);
    ensure_pram(idx * 2 + 1);
    drive_beat(ACT_FETCH, px, py, 16'($urandom), 8'($urandom));
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Drop valid, wait until every pixel is out and the block has settled,
  // then program all seven registers.
  task automatic apply_settings(logic [1:0] cb, logic [4:0] mb, logic c8, logic w,
                                logic t, logic [8:0] sx, logic [8:0] sy);
    in_bus.valid <= 1'b0;
    while (pixels_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_CHAR_BASE,  CFG_DATA_W'(cb));
    write_reg(REG_MAP_BASE,   CFG_DATA_W'(mb));
    write_reg(REG_COLOR_8BPP, CFG_DATA_W'(c8));
    write_reg(REG_MAP_WIDE,   CFG_DATA_W'(w));
    write_reg(REG_MAP_TALL,   CFG_DATA_W'(t));
    write_reg(REG_SCROLL_X,   sx);
    write_reg(REG_SCROLL_Y,   sy);
    cfg_we       <= 1'b0;
    map_base_now  = mb;
    char_base_now = cb;
    c8_now        = c8;
    wide_now      = w;
    tall_now      = t;
    sx_now        = sx;
    sy_now        = sy;
    n_settings++;
  endtask

  task automatic random_settings();
    apply_settings(2'($urandom_range(3)), 5'($urandom_range(31)),
                   1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 9'($urandom_range(511)),
                   9'($urandom_range(511)));
  endtask

  // One random beat, plus any writes that a fetch needs first
  task automatic random_beat();
    int          pick;
    logic [15:0] addr;
    pick    = $urandom_range(99);
    if (pick < 55) begin
      fetch_at(8'($urandom), 8'($urandom));
    end else if (pick < 80) begin
      // Half of the video writes land in the live map area to vary tiles
      if ($urandom_range(1))
        addr = 16'(int'(map_base_now) * MAP_BLOCK_BYTES
                   + $urandom_range(0, 4 * MAP_BLOCK_BYTES - 1));
      else
        addr = 16'($urandom);
      drive_beat(ACT_VRAM_WR, 8'($urandom), 8'($urandom), addr, 8'($urandom));
    end else if (pick < 95) begin
      drive_beat(ACT_PAL_WR, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      drive_beat(ACT_RESERVED, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int drain;
    int set_start;

    // Known values on every input from time zero
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_CHAR_BASE;
    cfg_data           = '0;
    in_bus.valid       = 1'b0;
    in_bus.action      = ACT_VRAM_WR;
    in_bus.pixel_x     = '0;
    in_bus.pixel_y     = '0;
    in_bus.mem_address = '0;
    in_bus.write_data  = '0;
    out_bus.ready      = 1'b0;
    send_idle_pct      = 21;
    recv_idle_pct      = 66;
    n_fetch            = 0;
    n_vwrite           = 0;
    n_pwrite           = 0;
    n_reserved         = 0;
    n_settings         = 0;
    n_beats            = 0;
    map_base_now       = '0;
    char_base_now      = '0;
    c8_now             = 1'b0;
    wide_now           = 1'b0;
    tall_now           = 1'b0;
    sx_now             = '0;
    sy_now             = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apply_settings(2'd0, 5'd0, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);

    // Directed: corner map entries, both flips, top bank, largest tile
    drive_beat(ACT_VRAM_WR, 8'd0, 8'd0, 16'h0000, 8'hFF);
    drive_beat(ACT_VRAM_WR, 8'd0, 8'd0, 16'h0001, 8'hFF);
    fetch_at(8'd0, 8'd0);
    fetch_at(8'd7, 8'd7);
    // Right edge of the first map row: tile zero, no flips, bank zero
    drive_beat(ACT_VRAM_WR, 8'd0, 8'd0, 16'h003E, 8'h00);
    drive_beat(ACT_VRAM_WR, 8'd0, 8'd0, 16'h003F, 8'h00);
    fetch_at(8'd255, 8'd0);
    fetch_at(8'd248, 8'd0);
    // Palette writes past the end wrap; set color bit 15 at entry 255
    drive_beat(ACT_PAL_WR, 8'd255, 8'd255, 16'hFFFF, 8'hFF);
    drive_beat(ACT_PAL_WR, 8'd255, 8'd255, 16'hFE00, 8'h80);
    fetch_at(8'd255, 8'd255);
    fetch_at(8'd0, 8'd255);
    drive_beat(ACT_VRAM_WR, 8'hFF, 8'hFF, 16'hFFFF, 8'h5A);
    // Unused action: accepted and dropped
    drive_beat(ACT_RESERVED, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    // Every register at its top value: map and tile reads wrap around memory
    apply_settings(2'd3, 5'd31, 1'b1, 1'b1, 1'b1, 9'd511, 9'd511);
    fetch_at(8'd0, 8'd0);
    fetch_at(8'd255, 8'd255);
    fetch_at(8'd1, 8'd0);

    // Random part in three stall regimes, three register settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 66;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        if (ph == 0 && s == 0)
          apply_settings(2'd0, 5'd0, 1'b0, 1'b0, 1'b0, 9'd0, 9'd0);
        else if (ph == 1 && s == 0)
          apply_settings(2'd3, 5'd31, 1'b1, 1'b1, 1'b1, 9'd511, 9'd511);
        else
          random_settings();
        set_start = n_beats;
        while (n_beats - set_start < BEATS_PER_SET) begin
          random_beat();
        end
      end
    end

    // Drain: hold valid low, wait for the last pixels, then let it settle
    in_bus.valid <= 1'b0;
    drain = 0;
    while (pixels_pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d fetches, %0d video and %0d palette writes, %0d reserved beats,",
             n_fetch, n_vwrite, n_pwrite, n_reserved);
    $display("across %0d register settings and three stall regimes.", n_settings);
    if (pixels_pending != 0)
      $display("%0d pixels never arrived", pixels_pending);
    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ tiled_background_pixel_fetch.f @@
rtl/core/tbpf_pkg.sv
rtl/core/tbpf_if.sv
rtl/core/tbpf_queue.sv
rtl/core/tbpf_front.sv
rtl/core/tbpf_back.sv
rtl/core/tiled_background_pixel_fetch.sv
rtl/core/tbpf_checker.sv
tb/sv/tbpf_pixel_checker.sv
tb/sv/tiled_background_pixel_fetch_test.sv
